@@ rtl/flk_pkg.sv @@
// ----------------------------------------------------------------------------
// flk_pkg: shared types and constants for the flock entry update block
// Item layouts, configuration record, controller/datapath command and status.
// ----------------------------------------------------------------------------
package flk_pkg;

    // fixed field widths
    localparam int IDX_W       = 6;
    localparam int DATA_W      = 16;
    localparam int FSIZE_W     = 7;
    localparam int DIST_W      = 15;
    localparam int OCNT_W      = 6;
    localparam int OUT_CNT_MAX = 63;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // parameter defaults
    localparam int FLOCK_MAX_DEF = 64;
    localparam int FRAC_BITS_DEF = 12;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOCK_SIZE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTRACT_DIST    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COHESION_GAIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALIGNMENT_GAIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEP_DIST        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEPARATION_GAIN = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SPEED       = 3'd6;

    // configuration reset values
    localparam logic [FSIZE_W-1:0]       RST_FLOCK_SIZE = 7'd64;
    localparam logic [DIST_W-1:0]        RST_ATTRACT    = 15'd410;
    localparam logic signed [DATA_W-1:0] RST_COH_GAIN   = 16'sd41;
    localparam logic signed [DATA_W-1:0] RST_ALN_GAIN   = 16'sd41;
    localparam logic [DIST_W-1:0]        RST_SEP        = 15'd205;
    localparam logic signed [DATA_W-1:0] RST_SEP_GAIN   = 16'sd41;
    localparam logic [DIST_W-1:0]        RST_MAX_SPEED  = 15'd41;

    // item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // steering terms, worked one after another
    localparam logic [2:0] TERM_COH_X = 3'd0;
    localparam logic [2:0] TERM_COH_Y = 3'd1;
    localparam logic [2:0] TERM_ALN_X = 3'd2;
    localparam logic [2:0] TERM_ALN_Y = 3'd3;
    localparam logic [2:0] TERM_SEP_X = 3'd4;
    localparam logic [2:0] TERM_SEP_Y = 3'd5;
    localparam logic [2:0] TERM_END   = 3'd6;

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] in_pos_x;
        logic signed [DATA_W-1:0] in_pos_y;
        logic signed [DATA_W-1:0] in_vel_x;
        logic signed [DATA_W-1:0] in_vel_y;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] out_pos_x;
        logic signed [DATA_W-1:0] out_pos_y;
        logic signed [DATA_W-1:0] out_vel_x;
        logic signed [DATA_W-1:0] out_vel_y;
        logic [OCNT_W-1:0]        attract_count;
        logic [OCNT_W-1:0]        separate_count;
    } out_item_t;

    typedef struct packed {
        logic [FSIZE_W-1:0]       flock_size;
        logic [DIST_W-1:0]        attract_dist;
        logic signed [DATA_W-1:0] cohesion_gain;
        logic signed [DATA_W-1:0] alignment_gain;
        logic [DIST_W-1:0]        sep_dist;
        logic signed [DATA_W-1:0] separation_gain;
        logic [DIST_W-1:0]        max_speed;
    } cfg_t;

    typedef struct packed {
        logic             accept;
        logic             rd_self;
        logic             self_ld;
        logic             scan_rd;
        logic [IDX_W-1:0] scan_addr;
        logic [2:0]       term;
        logic             div_start;
        logic             div_clamp;
        logic             mul_term;
        logic             acc_term;
        logic             sq_ld;
        logic             sqrt_start;
        logic             axis;
        logic             mul_clamp;
        logic             clamp_ld;
        logic             fin_upd;
        logic             fin_wr;
        logic             fin_bad;
        logic             out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic               is_write;
        logic               idx_bad;
        logic [FSIZE_W-1:0] scan_n;
        logic               ac_zero;
        logic               sc_zero;
        logic               div_done;
        logic               sqrt_done;
        logic               clamp_need;
    } dp_stat_t;

    // saturate to 16-bit signed
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [31:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 32'sd32767)
            r = 16'sh7FFF;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/flk_div.sv @@
// ----------------------------------------------------------------------------
// flk_div: restoring unsigned divider
// One quotient bit per cycle; dividend is left-aligned, iters bits are used.
// ----------------------------------------------------------------------------
module flk_div #(
    parameter int DVW = 38,
    parameter int DSW = 23,
    parameter int ITW = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    input  logic [ITW-1:0] iters,
    output logic [DVW-1:0] quotient,
    output logic           done
);

    logic [DSW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] quo_reg, quo_next;
    logic [DSW-1:0] dsr_reg;
    logic [ITW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DSW:0]   shifted;
    logic [DSW:0]   diff;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVW-1]};
        diff    = shifted - {1'b0, dsr_reg};
        if (shifted >= {1'b0, dsr_reg})
        begin
            rem_next = diff[DSW-1:0];
            quo_next = {quo_reg[DVW-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DSW-1:0];
            quo_next = {quo_reg[DVW-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= iters;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ITW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/flk_sqrt.sv @@
// ----------------------------------------------------------------------------
// flk_sqrt: iterative integer square root
// Bit-pair method, one result bit per cycle.
// ----------------------------------------------------------------------------
module flk_sqrt #(
    parameter int RW = 23
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root,
    output logic            done
);

    localparam int SW  = 2 * RW;
    localparam int CTW = $clog2(RW + 1);

    logic [SW-1:0]  v_reg, v_next;
    logic [SW-1:0]  res_reg, res_next;
    logic [SW-1:0]  bit_reg;
    logic [SW-1:0]  trial;
    logic [CTW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    // one step
    always_comb
    begin
        trial = res_reg + bit_reg;
        if (v_reg >= trial)
        begin
            v_next   = v_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            v_next   = v_reg;
            res_next = res_reg >> 1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CTW'(RW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(SW-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[RW-1:0];
    assign done = done_reg;

endmodule

@@ rtl/flk_dp.sv @@
// ----------------------------------------------------------------------------
// flk_dp: flock entry datapath
// Entry memory, neighbor scan pipeline, accumulators, shared multiplier,
// divider and square root, result register.
// ----------------------------------------------------------------------------
module flk_dp #(
    parameter int FLOCK_MAX = flk_pkg::FLOCK_MAX_DEF,
    parameter int FRAC_BITS = flk_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  flk_pkg::cfg_t      cfg,
    input  flk_pkg::in_item_t  in_data,
    input  flk_pkg::dp_cmd_t   cmd,
    output flk_pkg::dp_stat_t  stat,
    output flk_pkg::out_item_t out_data
);

    import flk_pkg::*;

    localparam int AW   = $clog2(FLOCK_MAX);
    localparam int CW   = $clog2(FLOCK_MAX + 1);
    localparam int SUMW = DATA_W + CW;
    localparam int VW   = 35 - FRAC_BITS;
    localparam int MW   = VW + DATA_W;
    localparam int DVW  = VW + DIST_W;
    localparam int ITW  = $clog2(DVW + 1);
    localparam int SQW  = 2 * VW;
    localparam int DXW  = DATA_W + 1;
    localparam int D2W  = 2 * DXW;
    localparam int EW   = 4 * DATA_W;
    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);

    // captured item
    in_item_t in_reg;

    // entry memory: {pos_x, pos_y, vel_x, vel_y}
    logic [EW-1:0] mem [FLOCK_MAX];
    logic [EW-1:0] mem_q;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [EW-1:0] mem_wdata;

    // entry under update
    logic signed [DATA_W-1:0] px_reg, py_reg;
    logic signed [VW-1:0]     vx_reg, vy_reg;

    // scan pipeline
    logic                     va_reg, vb_reg, vc_reg;
    logic                     skip_a_reg, skip_b_reg, skip_c_reg;
    logic signed [DXW-1:0]    dx_b_reg, dy_b_reg;
    logic [EW-1:0]            nd_b_reg, nd_c_reg;
    logic signed [D2W-1:0]    dx2_c_reg, dy2_c_reg;
    logic [D2W-1:0]           d2;
    logic [2*DIST_W-1:0]      a2_reg, s2_reg, ms2_reg;

    // accumulators
    logic [CW-1:0]            ac_reg, sc_reg;
    logic signed [SUMW-1:0]   spx_reg, spy_reg, svx_reg, svy_reg, qx_reg, qy_reg;

    // shared arithmetic
    logic signed [MW-1:0]     prod_reg, prod_next;
    logic [SQW-1:0]           sqx_reg, sqy_reg, sp2;
    logic                     div_neg_reg;

    // result
    logic signed [DATA_W-1:0] res_px_reg, res_py_reg, res_vx_reg, res_vy_reg;
    logic [OCNT_W-1:0]        res_ac_reg, res_sc_reg;
    out_item_t                out_reg;

    // neighbor fields
    logic signed [DATA_W-1:0] m_px, m_py;
    logic signed [DATA_W-1:0] c_px, c_py, c_vx, c_vy;

    // term selection
    logic signed [SUMW-1:0]   sum_sel;
    logic [CW-1:0]            cnt_sel;
    logic signed [DATA_W-1:0] gain_sel;
    logic signed [DATA_W-1:0] p_sel;
    logic [SUMW-1:0]          sum_mag;
    logic signed [DATA_W-1:0] mean;
    logic signed [DXW-1:0]    term_op;
    logic signed [VW-1:0]     v_ax;
    logic [VW-1:0]            v_mag;
    logic signed [VW-1:0]     mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [VW-1:0]     acc_add;

    // divider and root
    logic [DVW-1:0]           div_dividend, div_q;
    logic [VW-1:0]            div_divisor;
    logic [ITW-1:0]           div_iters;
    logic                     div_done;
    logic signed [DVW:0]      q_signed;
    logic [VW-1:0]            root;
    logic                     sqrt_done;

    // final values
    logic signed [DATA_W-1:0] fvx, fvy, fpx, fpy;

    function automatic logic signed [DATA_W-1:0] wrap_q(input logic signed [DATA_W-1:0] p);
        logic signed [DATA_W-1:0] r;
        if (p < -ONE_Q)
            r = ONE_Q;
        else if (p > ONE_Q)
            r = -ONE_Q;
        else
            r = p;
        return r;
    endfunction

    function automatic logic [OCNT_W-1:0] cnt_sat(input logic [CW-1:0] c);
        logic [OCNT_W-1:0] r;
        if (32'(c) > OUT_CNT_MAX)
            r = OCNT_W'(OUT_CNT_MAX);
        else
            r = OCNT_W'(c);
        return r;
    endfunction

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            in_reg <= in_data;
    end

    // memory: one read port, one write port
    assign rd_addr = cmd.rd_self ? in_reg.entry_index[AW-1:0] : cmd.scan_addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rd_self || cmd.scan_rd)
            mem_q <= mem[rd_addr];
        if (mem_we)
            mem[in_reg.entry_index[AW-1:0]] <= mem_wdata;
    end

    assign m_px = mem_q[4*DATA_W-1:3*DATA_W];
    assign m_py = mem_q[3*DATA_W-1:2*DATA_W];

    // squared radii
    always_ff @(posedge clk)
    begin
        a2_reg  <= cfg.attract_dist * cfg.attract_dist;
        s2_reg  <= cfg.sep_dist * cfg.sep_dist;
        ms2_reg <= cfg.max_speed * cfg.max_speed;
    end

    // scan pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= cmd.scan_rd;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // scan stages: offsets, then squares
    always_ff @(posedge clk)
    begin
        skip_a_reg <= (cmd.scan_addr == in_reg.entry_index);
        skip_b_reg <= skip_a_reg;
        skip_c_reg <= skip_b_reg;
        dx_b_reg   <= DXW'(m_px) - DXW'(px_reg);
        dy_b_reg   <= DXW'(m_py) - DXW'(py_reg);
        nd_b_reg   <= mem_q;
        dx2_c_reg  <= dx_b_reg * dx_b_reg;
        dy2_c_reg  <= dy_b_reg * dy_b_reg;
        nd_c_reg   <= nd_b_reg;
    end

    assign d2   = $unsigned(dx2_c_reg) + $unsigned(dy2_c_reg);
    assign c_px = nd_c_reg[4*DATA_W-1:3*DATA_W];
    assign c_py = nd_c_reg[3*DATA_W-1:2*DATA_W];
    assign c_vx = nd_c_reg[2*DATA_W-1:DATA_W];
    assign c_vy = nd_c_reg[DATA_W-1:0];

    // neighbor accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.self_ld)
        begin
            ac_reg  <= '0;
            sc_reg  <= '0;
            spx_reg <= '0;
            spy_reg <= '0;
            svx_reg <= '0;
            svy_reg <= '0;
            qx_reg  <= '0;
            qy_reg  <= '0;
        end
        else if (vc_reg && !skip_c_reg)
        begin
            if (d2 <= D2W'(a2_reg))
            begin
                ac_reg  <= ac_reg + 1'b1;
                spx_reg <= spx_reg + SUMW'(c_px);
                spy_reg <= spy_reg + SUMW'(c_py);
                svx_reg <= svx_reg + SUMW'(c_vx);
                svy_reg <= svy_reg + SUMW'(c_vy);
            end
            if (d2 < D2W'(s2_reg))
            begin
                sc_reg <= sc_reg + 1'b1;
                qx_reg <= qx_reg + SUMW'(c_px);
                qy_reg <= qy_reg + SUMW'(c_py);
            end
        end
    end

    // term operand selection
    always_comb
    begin
        case (cmd.term)
            TERM_COH_X:
            begin
                sum_sel = spx_reg;
                cnt_sel = ac_reg;
                gain_sel = cfg.cohesion_gain;
            end
            TERM_COH_Y:
            begin
                sum_sel = spy_reg;
                cnt_sel = ac_reg;
                gain_sel = cfg.cohesion_gain;
            end
            TERM_ALN_X:
            begin
                sum_sel = svx_reg;
                cnt_sel = ac_reg;
                gain_sel = cfg.alignment_gain;
            end
            TERM_ALN_Y:
            begin
                sum_sel = svy_reg;
                cnt_sel = ac_reg;
                gain_sel = cfg.alignment_gain;
            end
            TERM_SEP_X:
            begin
                sum_sel = qx_reg;
                cnt_sel = sc_reg;
                gain_sel = cfg.separation_gain;
            end
            default:
            begin
                sum_sel = qy_reg;
                cnt_sel = sc_reg;
                gain_sel = cfg.separation_gain;
            end
        endcase
    end

    assign p_sel    = cmd.term[0] ? py_reg : px_reg;
    assign sum_mag  = (sum_sel < 0) ? $unsigned(-sum_sel) : $unsigned(sum_sel);
    assign q_signed = div_neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign mean     = q_signed[DATA_W-1:0];

    always_comb
    begin
        case (cmd.term)
            TERM_COH_X, TERM_COH_Y: term_op = DXW'(mean) - DXW'(p_sel);
            TERM_ALN_X, TERM_ALN_Y: term_op = DXW'(mean);
            default:                term_op = DXW'(p_sel) - DXW'(mean);
        endcase
    end

    // clamp axis
    assign v_ax  = cmd.axis ? vy_reg : vx_reg;
    assign v_mag = (v_ax < 0) ? $unsigned(-v_ax) : $unsigned(v_ax);

    // shared multiplier
    assign mul_a     = cmd.mul_clamp ? $signed(v_mag) : VW'(term_op);
    assign mul_b     = cmd.mul_clamp ? $signed({1'b0, cfg.max_speed}) : gain_sel;
    assign prod_next = mul_a * mul_b;
    assign acc_add   = VW'(prod_reg >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_term || cmd.mul_clamp)
            prod_reg <= prod_next;
        if (cmd.div_start)
            div_neg_reg <= cmd.div_clamp ? (v_ax < 0) : (sum_sel < 0);
        if (cmd.sq_ld)
        begin
            sqx_reg <= $unsigned(SQW'(vx_reg) * SQW'(vx_reg));
            sqy_reg <= $unsigned(SQW'(vy_reg) * SQW'(vy_reg));
        end
    end

    assign sp2 = sqx_reg + sqy_reg;

    // divider operands
    assign div_dividend = cmd.div_clamp ? prod_reg[DVW-1:0]
                                        : {sum_mag, {(DVW-SUMW){1'b0}}};
    assign div_divisor  = cmd.div_clamp ? root : VW'(cnt_sel);
    assign div_iters    = cmd.div_clamp ? ITW'(DVW) : ITW'(SUMW);

    flk_div #(
        .DVW (DVW),
        .DSW (VW),
        .ITW (ITW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .quotient (div_q),
        .done     (div_done)
    );

    flk_sqrt #(
        .RW (VW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sp2),
        .root     (root),
        .done     (sqrt_done)
    );

    // entry state: load, steer, clamp
    always_ff @(posedge clk)
    begin
        if (cmd.self_ld)
        begin
            px_reg <= wrap_q(m_px);
            py_reg <= wrap_q(m_py);
            vx_reg <= VW'($signed(mem_q[2*DATA_W-1:DATA_W]));
            vy_reg <= VW'($signed(mem_q[DATA_W-1:0]));
        end
        else if (cmd.acc_term)
        begin
            if (cmd.term[0])
                vy_reg <= vy_reg + acc_add;
            else
                vx_reg <= vx_reg + acc_add;
        end
        else if (cmd.clamp_ld)
        begin
            if (cmd.axis)
                vy_reg <= VW'(q_signed);
            else
                vx_reg <= VW'(q_signed);
        end
    end

    // final saturation
    assign fvx = sat16(32'(vx_reg));
    assign fvy = sat16(32'(vy_reg));
    assign fpx = sat16(32'(px_reg) + 32'(fvx));
    assign fpy = sat16(32'(py_reg) + 32'(fvy));

    assign mem_we    = cmd.fin_upd || cmd.fin_wr;
    assign mem_wdata = cmd.fin_wr
                     ? {in_reg.in_pos_x, in_reg.in_pos_y, in_reg.in_vel_x, in_reg.in_vel_y}
                     : {fpx, fpy, fvx, fvy};

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.fin_upd)
        begin
            res_px_reg <= fpx;
            res_py_reg <= fpy;
            res_vx_reg <= fvx;
            res_vy_reg <= fvy;
            res_ac_reg <= cnt_sat(ac_reg);
            res_sc_reg <= cnt_sat(sc_reg);
        end
        else if (cmd.fin_wr)
        begin
            res_px_reg <= in_reg.in_pos_x;
            res_py_reg <= in_reg.in_pos_y;
            res_vx_reg <= in_reg.in_vel_x;
            res_vy_reg <= in_reg.in_vel_y;
            res_ac_reg <= '0;
            res_sc_reg <= '0;
        end
        else if (cmd.fin_bad)
        begin
            res_px_reg <= '0;
            res_py_reg <= '0;
            res_vx_reg <= '0;
            res_vy_reg <= '0;
            res_ac_reg <= '0;
            res_sc_reg <= '0;
        end
        if (cmd.out_ld)
        begin
            out_reg.out_index      <= in_reg.entry_index;
            out_reg.out_pos_x      <= res_px_reg;
            out_reg.out_pos_y      <= res_py_reg;
            out_reg.out_vel_x      <= res_vx_reg;
            out_reg.out_vel_y      <= res_vy_reg;
            out_reg.attract_count  <= res_ac_reg;
            out_reg.separate_count <= res_sc_reg;
        end
    end

    assign out_data = out_reg;

    // status
    assign stat.is_write   = (in_reg.op == OP_WRITE);
    assign stat.idx_bad    = ({1'b0, in_reg.entry_index} >= FSIZE_W'(FLOCK_MAX));
    assign stat.scan_n     = (cfg.flock_size > FSIZE_W'(FLOCK_MAX)) ? FSIZE_W'(FLOCK_MAX)
                                                                   : cfg.flock_size;
    assign stat.ac_zero    = (ac_reg == '0);
    assign stat.sc_zero    = (sc_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.sqrt_done  = sqrt_done;
    assign stat.clamp_need = (sp2 > SQW'(ms2_reg));

endmodule

@@ rtl/flk_ctrl.sv @@
// ----------------------------------------------------------------------------
// flk_ctrl: flock entry update sequencer
// Walks one item through read, scan, steering terms, speed clamp and result.
// ----------------------------------------------------------------------------
module flk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  flk_pkg::dp_stat_t stat,
    output flk_pkg::dp_cmd_t  cmd
);

    import flk_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_SELF  = 5'd2;
    localparam logic [4:0] S_SCAN  = 5'd3;
    localparam logic [4:0] S_DRAIN = 5'd4;
    localparam logic [4:0] S_TERM  = 5'd5;
    localparam logic [4:0] S_DIVW  = 5'd6;
    localparam logic [4:0] S_MUL   = 5'd7;
    localparam logic [4:0] S_ACC   = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_CMP   = 5'd10;
    localparam logic [4:0] S_SQW   = 5'd11;
    localparam logic [4:0] S_CMX   = 5'd12;
    localparam logic [4:0] S_CDIV  = 5'd13;
    localparam logic [4:0] S_CDW   = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    // scan pipeline depth after the last read
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [4:0]         state_reg, state_next;
    logic [FSIZE_W-1:0] j_reg, j_next;
    logic [1:0]         drain_reg, drain_next;
    logic [2:0]         term_reg, term_next;
    logic               axis_reg, axis_next;
    logic               out_valid_reg, out_valid_next;
    logic               term_skip;

    assign term_skip = (term_reg <= TERM_ALN_Y) ? stat.ac_zero : stat.sc_zero;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        j_next        = j_reg;
        drain_next    = drain_reg;
        term_next     = term_reg;
        axis_next     = axis_reg;
        cmd           = '0;
        cmd.scan_addr = j_reg[IDX_W-1:0];
        cmd.term      = term_reg;
        cmd.axis      = axis_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.idx_bad)
                begin
                    cmd.fin_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.is_write)
                begin
                    cmd.fin_wr = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_self = 1'b1;
                    state_next  = S_SELF;
                end
            end
            S_SELF:
            begin
                cmd.self_ld = 1'b1;
                j_next      = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (j_reg < stat.scan_n)
                begin
                    cmd.scan_rd = 1'b1;
                    j_next      = j_reg + 1'b1;
                end
                else
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    term_next  = TERM_COH_X;
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                if (term_reg == TERM_END)
                    state_next = S_SQ;
                else if (term_skip)
                    term_next = term_reg + 1'b1;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_term = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_term = 1'b1;
                term_next    = term_reg + 1'b1;
                state_next   = S_TERM;
            end
            S_SQ:
            begin
                cmd.sq_ld  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.clamp_need)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQW;
                end
                else
                    state_next = S_FIN;
            end
            S_SQW:
            begin
                if (stat.sqrt_done)
                begin
                    axis_next  = 1'b0;
                    state_next = S_CMX;
                end
            end
            S_CMX:
            begin
                cmd.mul_clamp = 1'b1;
                state_next    = S_CDIV;
            end
            S_CDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_clamp = 1'b1;
                state_next    = S_CDW;
            end
            S_CDW:
            begin
                cmd.div_clamp = 1'b1;
                if (stat.div_done)
                begin
                    cmd.clamp_ld = 1'b1;
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = S_CMX;
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin_upd = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        if (cmd.out_ld)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            drain_reg     <= '0;
            term_reg      <= TERM_COH_X;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            drain_reg     <= drain_next;
            term_reg      <= term_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/flock_entry_update.sv @@
// ----------------------------------------------------------------------------
// flock_entry_update: boid table with per-entry steering update
// Write item: stored and returned directly. Update item: self read, scan of n entries, one
// divide, multiply and accumulate per active steering term (23-step divide) and, when the
// speed limit applies, a root and one clamp divide per axis (38 steps); n is the scanned
// flock size (one entry read per cycle). One item at a time.
// Reset clears control and loads configuration defaults; table is unset until written.
// ----------------------------------------------------------------------------
module flock_entry_update #(
    parameter int FLOCK_MAX = flk_pkg::FLOCK_MAX_DEF,
    parameter int FRAC_BITS = flk_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  flk_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output flk_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [flk_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [flk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import flk_pkg::*;

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flock_size      <= RST_FLOCK_SIZE;
            cfg_reg.attract_dist    <= RST_ATTRACT;
            cfg_reg.cohesion_gain   <= RST_COH_GAIN;
            cfg_reg.alignment_gain  <= RST_ALN_GAIN;
            cfg_reg.sep_dist        <= RST_SEP;
            cfg_reg.separation_gain <= RST_SEP_GAIN;
            cfg_reg.max_speed       <= RST_MAX_SPEED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FLOCK_SIZE:      cfg_reg.flock_size      <= cfg_wdata[FSIZE_W-1:0];
                CFG_ATTRACT_DIST:    cfg_reg.attract_dist    <= cfg_wdata[DIST_W-1:0];
                CFG_COHESION_GAIN:   cfg_reg.cohesion_gain   <= $signed(cfg_wdata);
                CFG_ALIGNMENT_GAIN:  cfg_reg.alignment_gain  <= $signed(cfg_wdata);
                CFG_SEP_DIST:        cfg_reg.sep_dist        <= cfg_wdata[DIST_W-1:0];
                CFG_SEPARATION_GAIN: cfg_reg.separation_gain <= $signed(cfg_wdata);
                CFG_MAX_SPEED:       cfg_reg.max_speed       <= cfg_wdata[DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    flk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    flk_dp #(
        .FLOCK_MAX (FLOCK_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule
